// File: rtl/histogram_statistics_8bit_core_assert.svh
// Assertion macros for the histogram statistics block.
`ifndef HISTOGRAM_STATISTICS_8BIT_CORE_ASSERT_SVH
`define HISTOGRAM_STATISTICS_8BIT_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define HS_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("hs assertion failed");

// Antecedent implies consequent in the next cycle.
`define HS_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("hs assertion failed");

// Condition never holds.
`define HS_ASSERT_NEVER(lbl, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(c)) \
        else $error("hs assertion failed");

`endif

// File: rtl/hs_pkg.sv
package hs_pkg;

    localparam int BINS            = 256;
    localparam int ADDR_W          = 8;
    localparam int COUNT_WIDTH_DEF = 20;
    localparam int MEAN_MAX        = 65280;
    localparam int S2Q_MAX         = 65025;
    localparam int SIGMA_MAX       = 32640;
    localparam int MEDIAN_NONE     = 255;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_WRD,
        ST_WACC,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_S2_GO,
        ST_S2_WAIT,
        ST_FRAC_GO,
        ST_FRAC_WAIT,
        ST_VAR,
        ST_SQRT,
        ST_FINISH
    } hs_state_t;

endpackage

// File: rtl/histogram_statistics_8bit_core.sv
// Samples without last: the bin update is a read-modify-write, and no new sample is
// taken until its write is done. Sample with last: a walk over every bin, then three
// passes of the shared serial divider (one bit a cycle; the third is skipped when the
// mean square clamps) and a bitwise square root, then the result waits for a free
// output. No new item is taken meanwhile.
// Reset clears the bin valid bits, count and overflow flag: all bins read zero.
module histogram_statistics_8bit_core
    import hs_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  sample,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] mean_q8,
    output logic [14:0] sigma_q8,
    output logic [7:0]  min_value,
    output logic [7:0]  max_value,
    output logic [7:0]  median_value,
    output logic        overflow
);

    localparam int H    = COUNT_WIDTH;
    localparam int S1W  = H + 16;
    localparam int DW   = H + 24;
    localparam int CUMW = H + 8;

    hs_state_t state_reg, state_next;

    logic [BINS-1:0]   vld_reg;
    logic [H-1:0]      cnt_reg;
    logic              sat_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] s_reg;
    logic              last_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [15:0]       sq_reg;
    logic [S1W-1:0]    s1_reg;
    logic [DW-1:0]     s2_reg;
    logic [CUMW-1:0]   cum_reg;
    logic              any_reg;
    logic              found_reg;
    logic [7:0]        mn_reg, mx_reg, med_reg;
    logic [15:0]       mean_reg;
    logic [31:0]       msq_reg;
    logic [31:0]       m2_reg;
    logic [31:0]       v_reg, res_reg, bit_reg;
    logic [15:0]       mean_o_reg;
    logic [14:0]       sigma_o_reg;
    logic [7:0]        mn_o_reg, mx_o_reg, med_o_reg;
    logic              ovf_o_reg;

    logic              accept, load_out;
    logic [ADDR_W-1:0] raddr;
    logic [H-1:0]      rdata, h, wdata;
    logic              we;
    logic [H-1:0]      n;
    logic [CUMW-1:0]   cum_n;
    logic [H+7:0]      p1;
    logic [H+15:0]     p2;
    logic              div_start, div_done;
    logic [DW-1:0]     div_dividend, div_quot;
    logic [H-1:0]      div_rem;
    logic [31:0]       sq_trial;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);
    assign n        = (cnt_reg == '0) ? H'(1) : cnt_reg;

    assign raddr = (state_reg == ST_IDLE) ? sample : idx_reg;
    assign h     = (state_reg == ST_INC) ? (vld_reg[s_reg] ? rdata : '0)
                                         : (vld_reg[idx_reg] ? rdata : '0);
    assign wdata = (h == '1) ? h : h + 1'b1;
    assign we    = (state_reg == ST_INC);

    assign p1       = (H + 8)'(h) * (H + 8)'(idx_reg);
    assign p2       = (H + 16)'(h) * (H + 16)'(sq_reg);
    assign cum_n    = cum_reg + CUMW'(h);
    assign sq_trial = res_reg + bit_reg;

    hs_ram #(.WIDTH(H), .DEPTH(BINS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (s_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        div_dividend = '0;
        case (state_reg)
            ST_MEAN_GO: div_dividend = {s1_reg, 8'd0};
            ST_S2_GO:   div_dividend = s2_reg;
            default:    div_dividend = DW'({div_rem, 16'd0});
        endcase
    end

    assign div_start = (state_reg == ST_MEAN_GO) || (state_reg == ST_S2_GO)
                    || (state_reg == ST_FRAC_GO);

    hs_div #(.DW(DW), .VW(H)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (accept) state_next = ST_INC;
            ST_INC:       state_next = last_reg ? ST_WRD : ST_IDLE;
            ST_WRD:       state_next = ST_WACC;
            ST_WACC:      state_next = (idx_reg == ADDR_W'(BINS - 1)) ? ST_MEAN_GO : ST_WRD;
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (div_done) state_next = ST_S2_GO;
            ST_S2_GO:     state_next = ST_S2_WAIT;
            ST_S2_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (div_quot > DW'(S2Q_MAX)) ? ST_VAR : ST_FRAC_GO;
                end
            end
            ST_FRAC_GO:   state_next = ST_FRAC_WAIT;
            ST_FRAC_WAIT: if (div_done) state_next = ST_VAR;
            ST_VAR:       state_next = ST_SQRT;
            ST_SQRT:      if (bit_reg == '0) state_next = ST_FINISH;
            ST_FINISH:    if (load_out) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            vld_reg       <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INC)
            begin
                vld_reg[s_reg] <= 1'b1;
                if (cnt_reg != '1)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                else
                begin
                    sat_reg <= 1'b1;
                end
            end
            if (load_out)
            begin
                // drop the finished set
                vld_reg <= '0;
                cnt_reg <= '0;
                sat_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                s_reg     <= sample;
                last_reg  <= last;
                idx_reg   <= '0;
                sq_reg    <= '0;
                s1_reg    <= '0;
                s2_reg    <= '0;
                cum_reg   <= '0;
                any_reg   <= 1'b0;
                found_reg <= 1'b0;
                mn_reg    <= '0;
                mx_reg    <= '0;
                med_reg   <= 8'(MEDIAN_NONE);
            end
            ST_WACC:
            begin
                s1_reg  <= s1_reg + S1W'(p1);
                s2_reg  <= s2_reg + DW'(p2);
                cum_reg <= cum_n;
                if (h != '0)
                begin
                    if (!any_reg)
                    begin
                        mn_reg <= idx_reg;
                    end
                    mx_reg  <= idx_reg;
                    any_reg <= 1'b1;
                end
                if (!found_reg && (cum_n >= CUMW'(n >> 1)))
                begin
                    med_reg   <= idx_reg;
                    found_reg <= 1'b1;
                end
                sq_reg  <= sq_reg + {7'd0, idx_reg, 1'b0} + 16'd1;
                idx_reg <= idx_reg + 1'b1;
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    mean_reg <= (div_quot > DW'(MEAN_MAX)) ? 16'(MEAN_MAX) : div_quot[15:0];
                end
            end
            ST_S2_GO:
            begin
                msq_reg <= mean_reg * mean_reg;
            end
            ST_S2_WAIT:
            begin
                if (div_done)
                begin
                    m2_reg <= (div_quot > DW'(S2Q_MAX)) ? {16'(S2Q_MAX), 16'd0}
                                                        : {div_quot[15:0], 16'd0};
                end
            end
            ST_FRAC_WAIT:
            begin
                if (div_done)
                begin
                    m2_reg <= m2_reg + {16'd0, div_quot[15:0]};
                end
            end
            ST_VAR:
            begin
                v_reg   <= (m2_reg > msq_reg) ? m2_reg - msq_reg : '0;
                res_reg <= '0;
                bit_reg <= 32'h4000_0000;
            end
            ST_SQRT:
            begin
                if (bit_reg != '0)
                begin
                    if (v_reg >= sq_trial)
                    begin
                        v_reg   <= v_reg - sq_trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            mean_o_reg  <= mean_reg;
            sigma_o_reg <= (res_reg > 32'(SIGMA_MAX)) ? 15'(SIGMA_MAX) : res_reg[14:0];
            mn_o_reg    <= mn_reg;
            mx_o_reg    <= mx_reg;
            med_o_reg   <= med_reg;
            ovf_o_reg   <= sat_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mean_q8      = mean_o_reg;
    assign sigma_q8     = sigma_o_reg;
    assign min_value    = mn_o_reg;
    assign max_value    = mx_o_reg;
    assign median_value = med_o_reg;
    assign overflow     = ovf_o_reg;

`include "histogram_statistics_8bit_core_assert.svh"

    `HS_ASSERT_NXT(a_busy_after_accept, accept, in_stall)
    `HS_ASSERT_IMP(a_result_from_finish, $rose(out_valid), $past(state_reg == ST_FINISH))
    `HS_ASSERT_NEVER(a_no_div_done_idle, (state_reg == ST_IDLE) && div_done)

endmodule

// File: rtl/hs_ram.sv
module hs_ram
    import hs_pkg::*;
#(
    parameter int WIDTH = COUNT_WIDTH_DEF,
    parameter int DEPTH = BINS
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/hs_div.sv
module hs_div
    import hs_pkg::*;
#(
    parameter int DW = COUNT_WIDTH_DEF + 24,
    parameter int VW = COUNT_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [VW-1:0] rem
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] dq_reg;
    logic [VW-1:0] rem_reg;
    logic [VW:0]   trial;
    logic          ge;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, dq_reg[DW-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign done  = busy_reg && (cnt_reg == '0);
    assign quot  = dq_reg;
    assign rem   = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= ge ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
            dq_reg  <= {dq_reg[DW-2:0], ge};
        end
    end

endmodule

// File: sim/histogram_statistics_8bit_core_tb.sv
`timescale 1ns / 1ps

module histogram_statistics_8bit_core_tb;
    import hs_pkg::*;

    localparam int CW         = COUNT_WIDTH_DEF;
    localparam longint CMAX   = (64'd1 << CW) - 1;
    localparam int RAND_ITEMS = 800;
    localparam int DRAIN      = 530 + 3 * (CW + 25) + 100;
    localparam int STUCK_MAX  = 20000;

    typedef struct packed {
        logic [15:0] mean;
        logic [14:0] sigma;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  med;
        logic        ovf;
    } stats_t;

    typedef struct packed {
        logic [7:0] smp;
        logic       lst;
        logic       typed;
        stats_t     res;
    } row_t;

    localparam stats_t NONE = '0;
    localparam int NROWS = 20;
    // typed rows: lone zero, lone full scale, the two extremes together
    localparam row_t PLAN [NROWS] = '{
        '{8'd0,   1'b1, 1'b1, '{16'd0, 15'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
        '{8'd255, 1'b1, 1'b1, '{16'd65280, 15'd0, 8'd255, 8'd255, 8'd0, 1'b0}},
        '{8'd0,   1'b0, 1'b0, NONE},
        '{8'd255, 1'b1, 1'b1, '{16'd32640, 15'd32640, 8'd0, 8'd255, 8'd0, 1'b0}},
        '{8'd1,   1'b0, 1'b0, NONE},
        '{8'd2,   1'b0, 1'b0, NONE},
        '{8'd4,   1'b0, 1'b0, NONE},
        '{8'd8,   1'b0, 1'b0, NONE},
        '{8'd16,  1'b0, 1'b0, NONE},
        '{8'd32,  1'b0, 1'b0, NONE},
        '{8'd64,  1'b0, 1'b0, NONE},
        '{8'd128, 1'b1, 1'b0, NONE},
        '{8'd7,   1'b0, 1'b0, NONE},
        '{8'd7,   1'b0, 1'b0, NONE},
        '{8'd7,   1'b1, 1'b0, NONE},
        '{8'd200, 1'b0, 1'b0, NONE},
        '{8'd10,  1'b0, 1'b0, NONE},
        '{8'd100, 1'b1, 1'b0, NONE},
        '{8'd254, 1'b0, 1'b0, NONE},
        '{8'd1,   1'b1, 1'b0, NONE}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  sample;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] mean_q8;
    logic [14:0] sigma_q8;
    logic [7:0]  min_value;
    logic [7:0]  max_value;
    logic [7:0]  median_value;
    logic        overflow;

    histogram_statistics_8bit_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mean_q8      (mean_q8),
        .sigma_q8     (sigma_q8),
        .min_value    (min_value),
        .max_value    (max_value),
        .median_value (median_value),
        .overflow     (overflow)
    );

    longint unsigned bin_count [BINS];
    longint unsigned set_size;
    logic            set_sat;
    stats_t          pending_stats [$];
    int              errors;
    int              items_sent;
    int              sets_sent;
    int              stats_seen;
    bit              calm;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // Add one sample to the histogram; on last, compute the statistics and clear.
    function automatic bit histogram_add(input logic [7:0] s, input logic l,
                                         output stats_t r);
        longint unsigned n, s1, s2, mu, q, rem, m2, vr, sd, cum, half;
        int lo, hi, med;
        bit seen;
        s1 = 0;
        s2 = 0;
        lo = 0;
        hi = 0;
        med = MEDIAN_NONE;
        seen = 0;
        r = '0;
        if (bin_count[s] < CMAX)
            bin_count[s]++;
        if (set_size < CMAX)
            set_size++;
        else
            set_sat = 1'b1;
        if (!l)
            return 0;
        n = (set_size == 0) ? 1 : set_size;
        for (int i = 0; i < BINS; i++)
        begin
            s1 += bin_count[i] * i;
            s2 += bin_count[i] * i * i;
        end
        mu = (s1 * 256) / n;
        if (mu > MEAN_MAX)
            mu = MEAN_MAX;
        q = s2 / n;
        rem = s2 % n;
        if (q > S2Q_MAX)
        begin
            q = S2Q_MAX;
            rem = 0;
        end
        m2 = q * 65536 + (rem * 65536) / n;
        vr = (m2 > mu * mu) ? m2 - mu * mu : 0;
        sd = int_sqrt(vr);
        if (sd > SIGMA_MAX)
            sd = SIGMA_MAX;
        for (int i = 0; i < BINS; i++)
        begin
            if (bin_count[i] != 0)
            begin
                if (!seen)
                    lo = i;
                hi = i;
                seen = 1;
            end
        end
        half = n / 2;
        cum = 0;
        for (int i = 0; i < BINS; i++)
        begin
            cum += bin_count[i];
            if (cum >= half)
            begin
                med = i;
                break;
            end
        end
        r.mean = mu[15:0];
        r.sigma = sd[14:0];
        r.lo = lo[7:0];
        r.hi = hi[7:0];
        r.med = med[7:0];
        r.ovf = set_sat;
        for (int i = 0; i < BINS; i++)
            bin_count[i] = 0;
        set_size = 0;
        set_sat = 1'b0;
        return 1;
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        $display("mismatch on result %0d: %s got %0d, expected %0d",
                 stats_seen, field, got, want);
        errors++;
    endtask

    // Offer one item, hold it until taken, then predict.
    task automatic push_sample(input logic [7:0] s, input logic l,
                               input bit typed, input stats_t want);
        stats_t r;
        if (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        last <= l;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (histogram_add(s, l, r))
        begin
            sets_sent++;
            pending_stats.push_back(typed ? want : r);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(99) < 6);
    end

    always @(posedge clk)
    begin
        stats_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_stats.size() == 0)
            begin
                $display("result %0d arrived with nothing pending", stats_seen);
                errors++;
            end
            else
            begin
                e = pending_stats.pop_front();
                if (mean_q8 !== e.mean)
                    report_mismatch("mean_q8", mean_q8, e.mean);
                if (sigma_q8 !== e.sigma)
                    report_mismatch("sigma_q8", sigma_q8, e.sigma);
                if (min_value !== e.lo)
                    report_mismatch("min_value", min_value, e.lo);
                if (max_value !== e.hi)
                    report_mismatch("max_value", max_value, e.hi);
                if (median_value !== e.med)
                    report_mismatch("median_value", median_value, e.med);
                if (overflow !== e.ovf)
                    report_mismatch("overflow", overflow, e.ovf);
            end
            stats_seen++;
        end
    end

    int stuck;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_MAX)
        begin
            $display("no progress for %0d cycles", STUCK_MAX);
            $display("[histogram_statistics_8bit_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        int len, base, span;
        logic [7:0] s;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        last = 1'b0;
        errors = 0;
        items_sent = 0;
        sets_sent = 0;
        stats_seen = 0;
        calm = 0;
        set_size = 0;
        set_sat = 1'b0;
        for (int i = 0; i < BINS; i++)
            bin_count[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NROWS; i++)
            push_sample(PLAN[i].smp, PLAN[i].lst, PLAN[i].typed, PLAN[i].res);

        while (items_sent < NROWS + RAND_ITEMS)
        begin
            // quiet stretch with no idling on either side
            calm = (sets_sent >= 30 && sets_sent < 40);
            // drain everything once before going on
            if (sets_sent == 20 && set_size == 0)
            begin
                in_valid <= 1'b0;
                while (pending_stats.size() != 0)
                    @(posedge clk);
            end
            len = ($urandom_range(15) == 0) ? $urandom_range(300, 20)
                                            : $urandom_range(12, 1);
            base = $urandom_range(255);
            span = ($urandom_range(3) == 0) ? 255 : $urandom_range(20);
            for (int k = 0; k < len; k++)
            begin
                if (span == 255)
                    s = 8'($urandom_range(255));
                else
                    s = 8'((base + $urandom_range(span)) % BINS);
                push_sample(s, k == len - 1, 0, NONE);
            end
        end
        in_valid <= 1'b0;

        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d samples in %0d sets, %0d statistics results checked",
                 items_sent, sets_sent, stats_seen);
        if (errors == 0)
            $display("[histogram_statistics_8bit_core] OK");
        else
            $display("[histogram_statistics_8bit_core] ERROR");
        $finish;
    end

endmodule
